// ----- hw/rtl/pal_pkg.sv -----
// pal_pkg: shared types and constants for the positional array list
// command/result transaction structs, operation and status codes, sequencer states
// no dependencies

package pal_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 4;
    localparam int LENGTH_W = 5;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ILLEGAL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FOUND_W-1:0]  found_position;
        logic [LENGTH_W-1:0] length;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PUT,
        ST_FIND,
        ST_FINISH
    } state_t;

endpackage

// ----- hw/rtl/pal_ram.sv -----
// pal_ram: generic single write port, single read port RAM
// read data is registered; contents have no reset
// no dependencies

module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/positional_array_list_core.sv -----
// positional_array_list_core: ordered list of words with insert, delete and find
// a small sequencer walks the entry RAM one entry per cycle
// depends on pal_pkg and pal_ram
//
// usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one operation per transaction:
//   insert at a position, delete at a position, or find the first entry equal to a value.
//   res channel (res_valid / res_stall / res) returns exactly one result per command:
//   status, found position and the list length after the operation.
//   cmd_stall is high from acceptance until the result is loaded into the output
//   register; one command is in flight at a time.
//   insert walks the entries from the last one down to the position, moving each up
//   one slot, then writes the value at the position; delete moves each entry after
//   the position down one slot; find compares entries in order from the first and
//   stops on the first hit or at the end of the list. rejected or unused commands go
//   straight to the finish state without touching the RAM.
//   the walk is bounded by the single entry RAM port pair: each shift step moves one
//   entry (one read, one write) per cycle, and find compares one entry per cycle.
//   a pending result holds res steady while res_stall is high; the next command is
//   still taken, but its result waits until the output register is free.
//   reset empties the list; entry contents are not cleared, no clearing pass.

module positional_array_list_core #(
    parameter int CAPACITY   = pal_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  pal_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output pal_pkg::res_t res
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > pal_pkg::POS_W) ? CNT_W : pal_pkg::POS_W;

    pal_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             left_reg, left_next;
    logic [IDX_W-1:0]             rd_idx_reg, rd_idx_next;
    logic                         pend_reg, pend_next;
    logic [IDX_W-1:0]             pend_idx_reg, pend_idx_next;
    logic                         up_reg, up_next;
    logic [DATA_WIDTH-1:0]        val_reg, val_next;
    logic [IDX_W-1:0]             pos_reg, pos_next;
    logic [pal_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [pal_pkg::FOUND_W-1:0]  where_reg, where_next;
    logic                         res_valid_reg, res_valid_next;
    pal_pkg::res_t                res_reg, res_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                         cmd_fire;
    logic                         out_free;
    logic                         match;
    logic [CMP_W-1:0]             pos_ext;
    logic [CMP_W-1:0]             cnt_ext;
    pal_pkg::state_t              dec_state;
    logic [pal_pkg::STATUS_W-1:0] dec_status;
    logic [CNT_W-1:0]             dec_count;
    logic [CNT_W-1:0]             dec_left;
    logic [IDX_W-1:0]             dec_rd_idx;
    logic                         dec_up;

    pal_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_stall = (state_reg != pal_pkg::ST_IDLE);
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign match     = pend_reg && (ram_rdata == val_reg);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign pos_ext = CMP_W'(cmd.position);
    assign cnt_ext = CMP_W'(count_reg);

    // command decode: checks and start values of the walk
    always_comb
    begin
        dec_state  = pal_pkg::ST_FINISH;
        dec_status = pal_pkg::STATUS_OK;
        dec_count  = count_reg;
        dec_left   = '0;
        dec_rd_idx = '0;
        dec_up     = 1'b0;
        case (cmd.kind)
            pal_pkg::KIND_INSERT:
            begin
                if (count_reg >= CNT_W'(CAPACITY))
                begin
                    dec_status = pal_pkg::STATUS_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    dec_status = pal_pkg::STATUS_ILLEGAL;
                end
                else
                begin
                    // walk from the last entry down to the position
                    dec_state  = pal_pkg::ST_SHIFT;
                    dec_count  = count_reg + CNT_W'(1);
                    dec_left   = CNT_W'(cnt_ext - pos_ext);
                    dec_rd_idx = IDX_W'(count_reg - CNT_W'(1));
                    dec_up     = 1'b1;
                end
            end
            pal_pkg::KIND_DELETE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    dec_status = pal_pkg::STATUS_ILLEGAL;
                end
                else
                begin
                    // walk from the entry after the position up to the end
                    dec_state  = pal_pkg::ST_SHIFT;
                    dec_count  = count_reg - CNT_W'(1);
                    dec_left   = CNT_W'(cnt_ext - pos_ext - CMP_W'(1));
                    dec_rd_idx = IDX_W'(pos_ext + CMP_W'(1));
                end
            end
            pal_pkg::KIND_FIND:
            begin
                dec_state  = pal_pkg::ST_FIND;
                dec_status = pal_pkg::STATUS_NOTFOUND;
                dec_left   = count_reg;
            end
            default:
            begin
                dec_state = pal_pkg::ST_FINISH;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pal_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = dec_state;
                end
            end
            pal_pkg::ST_SHIFT:
            begin
                if ((left_reg == '0) && !pend_reg)
                begin
                    state_next = up_reg ? pal_pkg::ST_PUT : pal_pkg::ST_FINISH;
                end
            end
            pal_pkg::ST_PUT:
            begin
                state_next = pal_pkg::ST_FINISH;
            end
            pal_pkg::ST_FIND:
            begin
                if (match || ((left_reg == '0) && !pend_reg))
                begin
                    state_next = pal_pkg::ST_FINISH;
                end
            end
            pal_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = pal_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pal_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        count_next     = count_reg;
        left_next      = left_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        up_next        = up_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        status_next    = status_reg;
        where_next     = where_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        ram_we         = 1'b0;
        ram_waddr      = pend_idx_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = rd_idx_reg;
        case (state_reg)
            pal_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    count_next  = dec_count;
                    left_next   = dec_left;
                    rd_idx_next = dec_rd_idx;
                    pend_next   = 1'b0;
                    up_next     = dec_up;
                    val_next    = DATA_WIDTH'($unsigned(cmd.value));
                    pos_next    = IDX_W'(cmd.position);
                    status_next = dec_status;
                    where_next  = '0;
                end
            end
            pal_pkg::ST_SHIFT:
            begin
                // read one entry ahead, write the previous read to its new slot
                if (left_reg != '0)
                begin
                    left_next = left_reg - CNT_W'(1);
                    pend_next = 1'b1;
                    if (up_reg)
                    begin
                        rd_idx_next   = rd_idx_reg - IDX_W'(1);
                        pend_idx_next = rd_idx_reg + IDX_W'(1);
                    end
                    else
                    begin
                        rd_idx_next   = rd_idx_reg + IDX_W'(1);
                        pend_idx_next = rd_idx_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                ram_we = pend_reg;
            end
            pal_pkg::ST_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = val_reg;
            end
            pal_pkg::ST_FIND:
            begin
                if (left_reg != '0)
                begin
                    left_next     = left_reg - CNT_W'(1);
                    rd_idx_next   = rd_idx_reg + IDX_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (match)
                begin
                    status_next = pal_pkg::STATUS_OK;
                    where_next  = pal_pkg::FOUND_W'(pend_idx_reg);
                end
            end
            pal_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next         = 1'b1;
                    res_next.status         = status_reg;
                    res_next.found_position = where_reg;
                    res_next.length         = pal_pkg::LENGTH_W'(count_reg);
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pal_pkg::ST_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        up_reg       <= up_next;
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        status_reg   <= status_next;
        where_reg    <= where_next;
        res_reg      <= res_next;
    end

endmodule
